/* src/scc_pkg.sv */
package scc_pkg;

	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int HEIGHT_CAP       = 4096;
	localparam int LANES            = 4;
	localparam int PIX_W            = 8;
	localparam int CFG_W            = 13;
	localparam int CFG_IDX_W        = 2;
	localparam int H_W              = 13;
	localparam int ROW_W            = 12;
	localparam int CNT_W            = 3;

	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int CHANNELS_RESET = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_type_t;

	typedef struct packed {
		req_type_t        req_type;
		logic [PIX_W-1:0] chan0_in;
		logic [PIX_W-1:0] chan1_in;
		logic [PIX_W-1:0] chan2_in;
		logic [PIX_W-1:0] chan3_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] chan0_out;
		logic [PIX_W-1:0] chan1_out;
		logic [PIX_W-1:0] chan2_out;
		logic [PIX_W-1:0] chan3_out;
		logic             frame_last;
	} out_item_t;

	// image border position of the pixel being filtered
	typedef struct packed {
		logic at_left;
		logic at_right;
		logic at_top;
		logic at_bottom;
	} border_t;

endpackage

/* src/scc_line_buffer.sv */
module scc_line_buffer #(
	parameter int MAX_WIDTH    = scc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = scc_pkg::DEF_MAX_CHANNELS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     acc,
	input  logic [$clog2(MAX_WIDTH)-1:0]             acc_col,
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0]   acc_px,
	input  logic                                     ret,
	input  logic [$clog2(MAX_WIDTH)-1:0]             ret_col,
	output logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0]   mid,
	output logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0]   top
);
	import scc_pkg::*;

	localparam int LW = PIX_W * MAX_CHANNELS;

	logic [LW-1:0] mid_mem [MAX_WIDTH];
	logic [LW-1:0] top_mem [MAX_WIDTH];
	logic [LW-1:0] mid_s1;
	logic [LW-1:0] top_s1;
	logic [LW-1:0] byp_data_s1;
	logic          byp_s1;

	// previous row: read old word, write new pixel at the same column
	always_ff @(posedge clk) begin
		if (acc) begin
			mid_s1          <= mid_mem[acc_col];
			mid_mem[acc_col] <= acc_px;
		end
	end

	// row before: filled from the previous-row word when the item retires
	always_ff @(posedge clk) begin
		if (acc) begin
			top_s1      <= top_mem[acc_col];
			byp_data_s1 <= mid_s1;
		end
		if (ret) begin
			top_mem[ret_col] <= mid_s1;
		end
	end

	// same column written in the cycle of the read (one-pixel rows)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
		end else if (acc) begin
			byp_s1 <= ret && (ret_col == acc_col);
		end
	end

	assign mid = mid_s1;
	assign top = byp_s1 ? byp_data_s1 : top_s1;

endmodule

/* src/scc_kernel.sv */
module scc_kernel #(
	parameter int MAX_CHANNELS = scc_pkg::DEF_MAX_CHANNELS
) (
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0] center,
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0] left,
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0] right,
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0] up,
	input  logic [scc_pkg::PIX_W*MAX_CHANNELS-1:0] down,
	input  scc_pkg::border_t                       border,
	input  logic [scc_pkg::CNT_W-1:0]              nch,
	output scc_pkg::out_item_t                     item
);
	import scc_pkg::*;

	localparam int LW = PIX_W * MAX_CHANNELS;

	logic [LW-1:0]                l_sel, r_sel, u_sel, d_sel;
	logic [LANES-1:0][PIX_W-1:0] lane_res;

	always_comb begin
		logic signed [11:0] c12, l12, r12, u12, d12, acc;
		l_sel = border.at_left   ? center : left;
		r_sel = border.at_right  ? center : right;
		u_sel = border.at_top    ? center : up;
		d_sel = border.at_bottom ? center : down;
		lane_res = '0;
		for (int k = 0; k < MAX_CHANNELS; k++) begin
			c12 = {4'b0000, center[k*PIX_W +: PIX_W]};
			l12 = {4'b0000, l_sel[k*PIX_W +: PIX_W]};
			r12 = {4'b0000, r_sel[k*PIX_W +: PIX_W]};
			u12 = {4'b0000, u_sel[k*PIX_W +: PIX_W]};
			d12 = {4'b0000, d_sel[k*PIX_W +: PIX_W]};
			acc = (c12 <<< 2) + c12 - l12 - r12 - u12 - d12;
			if (CNT_W'(k) < nch) begin
				if (acc[11]) begin
					lane_res[k] = '0;
				end else if (acc > 12'sd255) begin
					lane_res[k] = '1;
				end else begin
					lane_res[k] = acc[PIX_W-1:0];
				end
			end
		end
		item.chan0_out  = lane_res[0];
		item.chan1_out  = lane_res[1];
		item.chan2_out  = lane_res[2];
		item.chan3_out  = lane_res[3];
		item.frame_last = border.at_right && border.at_bottom;
	end

endmodule

/* src/sharpen_3x3_convolution_core.sv */
// Channel   Direction  Handshake          Payload
// pixel     in         valid / stall      in_item_t (req_type, chan0..3_in)
// result    out        valid / stall      out_item_t (chan0..3_out, frame_last)
// cfg       in         valid / ready      cfg_index, cfg_data
//
// One item per clock sustained while pixel_stall is low. An item is accepted
// into stage s1 (line buffer read and write); as s1 retires it, any result
// loads the result register. Reset clears counters, window and handshake state;
// line memories are not cleared. Pixel stall rises only while s1 holds a result
// that cannot enter a full, stalled result register; cfg_ready is always high.
module sharpen_3x3_convolution_core #(
	parameter int MAX_WIDTH    = scc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = scc_pkg::DEF_MAX_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  scc_pkg::in_item_t               pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output scc_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scc_pkg::CFG_W-1:0]       cfg_data
);
	import scc_pkg::*;

	localparam int LW     = PIX_W * MAX_CHANNELS;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int CMPW   = (WW > CFG_W) ? WW : CFG_W;
	localparam int W_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int CH_RST = (CHANNELS_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS_RESET;

	// clamped register values
	logic [WW-1:0]    eff_w_q;
	logic [H_W-1:0]   eff_h_q;
	logic [CNT_W-1:0] nch_q;

	// stream and image position
	logic [CW-1:0]    in_col_q;
	logic [1:0]       row_ph_q;   // input row, saturating at 2
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	// stage s1
	logic             v_s1;
	logic             emit_s1;
	border_t          border_s1;
	logic [LW-1:0]    px_s1;
	logic [CW-1:0]    col_s1;

	logic [LW-1:0]    win_q [9];
	logic [LW-1:0]    mid, top;
	out_item_t        result_q;
	out_item_t        kern_item;
	logic             result_valid_q;

	logic             accept, s1_adv;
	logic             emit, last;
	border_t          border;
	logic [LW-1:0]    in_px;
	logic [WW-1:0]    in_col_nx, out_col_nx;
	logic [H_W-1:0]   out_row_nx;
	logic [CMPW-1:0]  fw_ext;

	// s1 moves on unless it carries a result and the result register is stuck
	assign s1_adv      = v_s1 && (!emit_s1 || !result_valid_q || !result_stall);
	assign pixel_stall = v_s1 && !s1_adv;
	assign accept      = pixel_valid && !pixel_stall;
	assign cfg_ready   = 1'b1;

	assign in_px = (pixel.req_type == REQ_PIXEL)
		? LW'({pixel.chan3_in, pixel.chan2_in, pixel.chan1_in, pixel.chan0_in})
		: '0;

	// output lags input by one row and one pixel
	assign emit       = (row_ph_q == 2'd2) || ((row_ph_q == 2'd1) && (in_col_q != '0));
	assign in_col_nx  = WW'(in_col_q) + WW'(1);
	assign out_col_nx = WW'(out_col_q) + WW'(1);
	assign out_row_nx = H_W'(out_row_q) + H_W'(1);

	assign border.at_left   = (out_col_q == '0);
	assign border.at_right  = (out_col_nx >= eff_w_q);
	assign border.at_top    = (out_row_q == '0);
	assign border.at_bottom = (out_row_nx >= eff_h_q);
	assign last = emit && border.at_right && border.at_bottom;

	assign fw_ext = CMPW'(cfg_data);

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q   <= WW'(W_RST);
			eff_h_q   <= H_W'(HEIGHT_RESET);
			nch_q     <= CNT_W'(CH_RST);
			in_col_q  <= '0;
			row_ph_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (fw_ext == '0) begin
						eff_w_q <= WW'(1);
					end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
						eff_w_q <= WW'(MAX_WIDTH);
					end else begin
						eff_w_q <= WW'(fw_ext);
					end
					in_col_q  <= '0;
					row_ph_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data == '0) begin
						eff_h_q <= H_W'(1);
					end else if (cfg_data > H_W'(HEIGHT_CAP)) begin
						eff_h_q <= H_W'(HEIGHT_CAP);
					end else begin
						eff_h_q <= cfg_data;
					end
					in_col_q  <= '0;
					row_ph_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_CHANNEL_COUNT: begin
					if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_CHANNELS)) begin
						nch_q <= CNT_W'(MAX_CHANNELS);
					end else begin
						nch_q <= cfg_data[CNT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (last) begin
				// frame done: next item opens a new frame
				in_col_q  <= '0;
				row_ph_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_nx >= eff_w_q) begin
					in_col_q <= '0;
					if (row_ph_q != 2'd2) begin
						row_ph_q <= row_ph_q + 2'd1;
					end
				end else begin
					in_col_q <= CW'(in_col_nx);
				end
				if (emit) begin
					if (border.at_right) begin
						out_col_q <= '0;
						out_row_q <= ROW_W'(out_row_nx);
					end else begin
						out_col_q <= CW'(out_col_nx);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1   <= emit;
			border_s1 <= border;
			px_s1     <= in_px;
			col_s1    <= in_col_q;
		end
	end

	scc_line_buffer #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_line_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (accept),
		.acc_col (in_col_q),
		.acc_px  (in_px),
		.ret     (s1_adv),
		.ret_col (col_s1),
		.mid     (mid),
		.top     (top)
	);

	// 3x3 window, column 2 is the newest; shifts as each item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	// filter taps taken from the window as it will stand after the shift
	scc_kernel #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_kernel (
		.center (win_q[5]),
		.left   (win_q[4]),
		.right  (mid),
		.up     (win_q[2]),
		.down   (win_q[8]),
		.border (border_s1),
		.nch    (nch_q),
		.item   (kern_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			result_q <= kern_item;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(s1_adv && emit_s1))
		else $error("result appeared without a retiring item");

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(in_col_q) < eff_w_q)
		else $error("input column beyond frame width");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		H_W'(out_row_q) < eff_h_q)
		else $error("output row beyond frame height");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_adv |=> v_s1 && $stable(col_s1) && $stable(px_s1))
		else $error("stalled stage s1 lost its item");

endmodule
